### src/ffsa_pkg.sv
// Shared constants, types and codes of the first-fit segment allocator.
package ffsa_pkg;

  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int ADDR_BITS_DEF    = 16;

  localparam int OWNER_W  = 8;
  localparam int SIZE_W   = 17;
  localparam int START_W  = 16;
  localparam int STATUS_W = 2;
  localparam int HEAP_W   = 17;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] REG_HEAP_SIZE = 2'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;        // reload the table with one free segment
    logic load;        // capture the request word
    logic scan_clear;  // reset the scan index
    logic scan_step;   // advance the scan index
    logic take_exact;  // give the matched segment to the owner as it stands
    logic split;       // carve the request from the matched segment
    logic mark_free;   // release the matched segment
    logic merge_left;  // join the matched segment onto its left neighbour
    logic merge_right; // join the right neighbour onto the matched segment
    logic shift_step;  // one step of moving entries up or down
    logic shift_up;    // direction of the move
    logic shift_clear; // prepare the shift cursor
    logic save_grant;  // record the granted start
  } ffsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_free_cmd;
    logic zero_size;
    logic scan_done;   // index has passed the last segment
    logic hit;         // current entry matches the request
    logic exact;       // matched segment is exactly the request length
    logic full;        // table holds the maximum number of segments
    logic left_free;   // matched entry has a free left neighbour
    logic right_free;  // matched entry has a free right neighbour
    logic shift_done;
  } ffsa_stat_t;

endpackage

### src/ffsa_ctrl.sv
// Controller state machine of the first-fit segment allocator.
module ffsa_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        cfg_write,
  input  ffsa_pkg::ffsa_stat_t        stat,
  output ffsa_pkg::ffsa_cmd_t         cmd,
  output logic                        busy,
  output logic                        done,
  output logic [ffsa_pkg::STATUS_W-1:0] status
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_OPEN   = 4'd2;
  localparam logic [3:0] S_SPLIT  = 4'd3;
  localparam logic [3:0] S_FREE   = 4'd4;
  localparam logic [3:0] S_MLEFT  = 4'd5;
  localparam logic [3:0] S_CLOSEL = 4'd6;
  localparam logic [3:0] S_RCHK   = 4'd7;
  localparam logic [3:0] S_MRIGHT = 4'd8;
  localparam logic [3:0] S_CLOSER = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state, state_next;
  logic [ffsa_pkg::STATUS_W-1:0] result, result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      result <= ffsa_pkg::ST_OK;
    end else begin
      state  <= state_next;
      result <= result_next;
    end
  end

  always_comb begin
    state_next  = state;
    result_next = result;
    cmd         = '0;
    cmd.init    = cfg_write;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load       = 1'b1;
          cmd.scan_clear = 1'b1;
          result_next    = ffsa_pkg::ST_OK;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.is_free_cmd && stat.zero_size) begin
          result_next = ffsa_pkg::ST_NO_FIT;
          state_next  = S_DONE;
        end else if (stat.scan_done) begin
          result_next = stat.is_free_cmd ? ffsa_pkg::ST_NOT_FOUND : ffsa_pkg::ST_NO_FIT;
          state_next  = S_DONE;
        end else if (!stat.hit) begin
          cmd.scan_step = 1'b1;
        end else if (stat.is_free_cmd) begin
          cmd.mark_free = 1'b1;
          state_next    = S_FREE;
        end else if (stat.exact) begin
          cmd.take_exact = 1'b1;
          cmd.save_grant = 1'b1;
          state_next     = S_DONE;
        end else if (stat.full) begin
          result_next = ffsa_pkg::ST_FULL;
          state_next  = S_DONE;
        end else begin
          cmd.shift_clear = 1'b1;
          cmd.shift_up    = 1'b1;
          cmd.save_grant  = 1'b1;
          state_next      = S_OPEN;
        end
      end
      S_OPEN: begin
        cmd.shift_up = 1'b1;
        if (stat.shift_done) begin
          cmd.split  = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_FREE: begin
        if (stat.left_free) begin
          cmd.merge_left  = 1'b1;
          cmd.shift_clear = 1'b1;
          state_next      = S_CLOSEL;
        end else begin
          state_next = S_RCHK;
        end
      end
      S_CLOSEL: begin
        if (stat.shift_done) begin
          state_next = S_RCHK;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_RCHK: begin
        if (stat.right_free) begin
          cmd.merge_right = 1'b1;
          cmd.shift_clear = 1'b1;
          state_next      = S_CLOSER;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CLOSER: begin
        if (stat.shift_done) begin
          state_next = S_DONE;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);
  assign status = result;

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state != S_IDLE))
    else $error("done without a request in progress");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("controller did not return to idle");
  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request not taken up");

endmodule

### src/ffsa_dp.sv
// Datapath of the first-fit segment allocator: segment table, scan and shift logic.
module ffsa_dp #(
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ffsa_pkg::ffsa_cmd_t           cmd,
  input  logic [ffsa_pkg::HEAP_W-1:0]   heap_value,
  input  logic                          command,
  input  logic [ffsa_pkg::OWNER_W-1:0]  owner_id,
  input  logic [ffsa_pkg::SIZE_W-1:0]   request_size,
  input  logic [ffsa_pkg::START_W-1:0]  block_start,
  output ffsa_pkg::ffsa_stat_t          stat,
  output logic [ffsa_pkg::START_W-1:0]  grant
);

  localparam int ADDR_BITS = ffsa_pkg::ADDR_BITS_DEF;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int LW = ADDR_BITS + 1;

  logic                          seg_free  [MAX_SEGMENTS];
  logic [ffsa_pkg::OWNER_W-1:0]  seg_owner [MAX_SEGMENTS];
  logic [ADDR_BITS-1:0]          seg_start [MAX_SEGMENTS];
  logic [LW-1:0]                 seg_len   [MAX_SEGMENTS];
  logic [CW-1:0]                 count;

  logic                          req_cmd;
  logic [ffsa_pkg::OWNER_W-1:0]  req_owner;
  logic [ffsa_pkg::SIZE_W-1:0]   req_size;
  logic [ffsa_pkg::START_W-1:0]  req_start;
  logic [CW-1:0]                 idx;
  logic [CW-1:0]                 cur;
  logic [CW-1:0]                 stop;
  logic                          closing;
  logic [LW-1:0]                 init_len;

  logic [IW-1:0] ix, ixl, ixr;
  logic [IW-1:0] cx, cxm, cxp;
  logic          ent_free;
  logic [LW-1:0] ent_len;
  logic [ffsa_pkg::SIZE_W:0] size_ext;
  logic [ffsa_pkg::SIZE_W:0] len_ext;

  assign ix  = idx[IW-1:0];
  assign ixl = ix - IW'(1);
  assign ixr = ix + IW'(1);
  assign cx  = cur[IW-1:0];
  assign cxm = cx - IW'(1);
  assign cxp = cx + IW'(1);
  assign ent_free = seg_free[ix];
  assign ent_len  = seg_len[ix];
  assign size_ext = {1'b0, req_size};
  assign len_ext  = (ffsa_pkg::SIZE_W + 1)'(ent_len);
  assign init_len = rst ? LW'(1 << ADDR_BITS) : LW'(heap_value);

  always_comb begin
    stat             = '0;
    stat.is_free_cmd = (req_cmd == ffsa_pkg::CMD_FREE);
    stat.zero_size   = (req_size == '0);
    stat.scan_done   = (idx >= count);
    if (req_cmd == ffsa_pkg::CMD_FREE) begin
      stat.hit = !ent_free && (seg_owner[ix] == req_owner) &&
                 ((ffsa_pkg::START_W + ADDR_BITS)'(seg_start[ix]) ==
                  (ffsa_pkg::START_W + ADDR_BITS)'(req_start));
    end else begin
      stat.hit = ent_free && (len_ext >= size_ext);
    end
    stat.exact      = (len_ext == size_ext);
    stat.full       = (count >= CW'(MAX_SEGMENTS));
    stat.left_free  = (idx != '0) && seg_free[ixl];
    stat.right_free = (idx + CW'(1) < count) && seg_free[ixr];
    stat.shift_done = (cur == stop);
  end

  // Request and grant registers. The shift cursor (below): moving up it runs from
  // count down to idx+1, moving down from the removed slot up to the last entry.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd   <= command;
      req_owner <= owner_id;
      req_size  <= request_size;
      req_start <= block_start;
    end
    if (cmd.save_grant) begin
      grant <= ffsa_pkg::START_W'(seg_start[ix]);
    end else if (cmd.load) begin
      grant <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        seg_free[k]  <= (k == 0);
        seg_owner[k] <= '0;
        seg_start[k] <= '0;
        seg_len[k]   <= (k == 0) ? init_len : '0;
      end
      count      <= CW'(1);
      idx        <= '0;
      cur        <= '0;
      stop       <= '0;
    end else begin
      if (cmd.scan_clear) idx <= '0;
      if (cmd.scan_step)  idx <= idx + CW'(1);
      if (cmd.shift_clear) begin
        if (cmd.shift_up) begin
          cur  <= count;
          stop <= idx;
        end else if (cmd.merge_left) begin
          cur  <= idx;
          stop <= count - CW'(1);
          idx  <= idx - CW'(1);
        end else begin
          cur  <= idx + CW'(1);
          stop <= count - CW'(1);
        end
      end
      if (cmd.shift_step) begin
        if (cmd.shift_up) begin
          seg_free[cx]  <= seg_free[cxm];
          seg_owner[cx] <= seg_owner[cxm];
          seg_start[cx] <= seg_start[cxm];
          seg_len[cx]   <= seg_len[cxm];
          cur <= cur - CW'(1);
        end else begin
          seg_free[cx]  <= seg_free[cxp];
          seg_owner[cx] <= seg_owner[cxp];
          seg_start[cx] <= seg_start[cxp];
          seg_len[cx]   <= seg_len[cxp];
          cur <= cur + CW'(1);
        end
      end
      // A close finishes by clearing the old last entry.
      if (!cmd.shift_step && !cmd.shift_clear && !cmd.shift_up && (cur == stop) &&
          (cur != '0) && (count != '0) && (stop == count - CW'(1)) && closing) begin
        seg_free[cx]  <= 1'b0;
        seg_owner[cx] <= '0;
        seg_start[cx] <= '0;
        seg_len[cx]   <= '0;
        count         <= count - CW'(1);
      end
      if (cmd.take_exact) begin
        seg_free[ix]  <= 1'b0;
        seg_owner[ix] <= req_owner;
      end
      if (cmd.split) begin
        seg_free[ix]   <= 1'b0;
        seg_owner[ix]  <= req_owner;
        seg_len[ix]    <= LW'(req_size);
        seg_start[ixr] <= seg_start[ix] + ADDR_BITS'(req_size);
        seg_len[ixr]   <= seg_len[ix] - LW'(req_size);
        count          <= count + CW'(1);
      end
      if (cmd.mark_free) begin
        seg_free[ix]  <= 1'b1;
        seg_owner[ix] <= '0;
      end
      if (cmd.merge_left) begin
        seg_len[ixl] <= seg_len[ixl] + seg_len[ix];
      end
      if (cmd.merge_right) begin
        seg_len[ix] <= seg_len[ix] + seg_len[ixr];
      end
    end
  end

  // Marks that a close is under way so that its tail clear runs once.
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      closing <= 1'b0;
    end else if (cmd.shift_clear && !cmd.shift_up) begin
      closing <= 1'b1;
    end else if (closing && !cmd.shift_step && (cur == stop)) begin
      closing <= 1'b0;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CW'(MAX_SEGMENTS)))
    else $error("segment count out of range");
  a_split_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.split && !cmd.init) |=> (count == $past(count) + CW'(1)))
    else $error("split did not grow the table");
  a_first_free_start: assert property (@(posedge clk) disable iff (rst)
    seg_start[0] == '0)
    else $error("first segment does not start at zero");

endmodule

### src/first_fit_segment_allocator.sv
// First-fit segment allocator with coalescing: top level.
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with done high and cannot be stalled. An allocate
// scans the segment table one entry a cycle and a split then moves entries up
// one a cycle; a free that merges on both sides moves entries twice. busy stays
// high through the scan and the shifts. Writing heap_size rebuilds the table as
// one free segment.
module first_fit_segment_allocator #(
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [1:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           start,
  output logic                           busy,
  input  logic                           command,
  input  logic [ffsa_pkg::OWNER_W-1:0]   owner_id,
  input  logic [ffsa_pkg::SIZE_W-1:0]    request_size,
  input  logic [ffsa_pkg::START_W-1:0]   block_start,
  output logic                           done,
  output logic [ffsa_pkg::STATUS_W-1:0]  status,
  output logic [ffsa_pkg::START_W-1:0]   granted_start
);

  localparam int ADDR_BITS = ffsa_pkg::ADDR_BITS_DEF;
  localparam logic [ffsa_pkg::HEAP_W-1:0] HEAP_MAX = ffsa_pkg::HEAP_W'(1 << ADDR_BITS);

  logic [ffsa_pkg::HEAP_W-1:0] heap_size;
  logic [ffsa_pkg::HEAP_W-1:0] heap_clamped;
  logic [ffsa_pkg::HEAP_W-1:0] wr_val;
  logic                        cfg_write;
  ffsa_pkg::ffsa_cmd_t         cmd;
  ffsa_pkg::ffsa_stat_t        stat;
  logic [ffsa_pkg::START_W-1:0] grant;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == ffsa_pkg::REG_HEAP_SIZE);
  assign wr_val    = pwdata[ffsa_pkg::HEAP_W-1:0];

  always_comb begin
    if (wr_val == '0) heap_clamped = ffsa_pkg::HEAP_W'(1);
    else if (wr_val > HEAP_MAX) heap_clamped = HEAP_MAX;
    else heap_clamped = wr_val;
  end

  always_ff @(posedge clk) begin
    if (rst) heap_size <= HEAP_MAX;
    else if (cfg_write) heap_size <= heap_clamped;
  end

  assign prdata = (paddr == ffsa_pkg::REG_HEAP_SIZE) ? 32'(heap_size) : 32'd0;

  ffsa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cfg_write(cfg_write), .stat(stat),
    .cmd(cmd), .busy(busy), .done(done), .status(status)
  );

  ffsa_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .heap_value(heap_clamped),
    .command(command), .owner_id(owner_id), .request_size(request_size),
    .block_start(block_start), .stat(stat), .grant(grant)
  );

  assign granted_start = (status == ffsa_pkg::ST_OK) ? grant : '0;

endmodule

### dv/tb_first_fit_segment_allocator.sv
// Self-checking testbench for the first-fit segment allocator.
`timescale 1ns / 100ps

module tb_first_fit_segment_allocator;

  localparam int NSEG = ffsa_pkg::MAX_SEGMENTS_DEF;
  localparam int HEAP_MAX = 1 << ffsa_pkg::ADDR_BITS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  // Table copies: one follows accepted words, one runs ahead for stimulus.
  localparam int TAB_CHECK = 0;
  localparam int TAB_PLAN = 1;

  typedef struct packed {
    logic                         cmd;
    logic [ffsa_pkg::OWNER_W-1:0] owner;
    logic [ffsa_pkg::SIZE_W-1:0]  size;
    logic [ffsa_pkg::START_W-1:0] bstart;
  } request_t;

  typedef struct packed {
    logic [ffsa_pkg::STATUS_W-1:0] status;
    logic [ffsa_pkg::START_W-1:0]  grant;
  } reply_t;

  typedef struct packed {
    logic                         is_free;
    logic [ffsa_pkg::OWNER_W-1:0] owner;
    logic [ffsa_pkg::START_W-1:0] base;
    logic [ffsa_pkg::HEAP_W-1:0]  len;
  } segment_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic command = ffsa_pkg::CMD_ALLOC;
  logic [ffsa_pkg::OWNER_W-1:0] owner_id = '0;
  logic [ffsa_pkg::SIZE_W-1:0] request_size = '0;
  logic [ffsa_pkg::START_W-1:0] block_start = '0;
  logic done;
  logic [ffsa_pkg::STATUS_W-1:0] status;
  logic [ffsa_pkg::START_W-1:0] granted_start;

  first_fit_segment_allocator dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .command(command), .owner_id(owner_id), .request_size(request_size),
    .block_start(block_start),
    .done(done), .status(status), .granted_start(granted_start)
  );

  segment_t segs [2][NSEG];
  int seg_cnt [2];
  int heap_units;

  request_t pending_words[$];
  reply_t expected_replies[$];
  request_t word_on_bus;
  int gap_left = 0;
  bit quiet_phase = 0;
  int errors = 0;
  int cycles = 0;

  initial forever #10 clk = ~clk;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void table_reload(input int w);
    for (int k = 0; k < NSEG; k++) segs[w][k] = '0;
    segs[w][0].is_free = 1'b1;
    segs[w][0].len = heap_units[ffsa_pkg::HEAP_W-1:0];
    seg_cnt[w] = 1;
  endfunction

  function automatic void remove_entry(input int w, input int pos);
    for (int k = pos; k + 1 < seg_cnt[w]; k++) segs[w][k] = segs[w][k+1];
    seg_cnt[w]--;
    segs[w][seg_cnt[w]] = '0;
  endfunction

  // Applies one word to a table copy and returns the reply it produces.
  function automatic reply_t allocate_or_release(input int w, input request_t rq);
    reply_t r;
    int i;
    r.status = ffsa_pkg::ST_NO_FIT;
    r.grant = '0;
    if (rq.cmd == ffsa_pkg::CMD_ALLOC) begin
      if (rq.size == 0) return r;
      for (i = 0; i < seg_cnt[w]; i++) begin
        if (!segs[w][i].is_free || segs[w][i].len < rq.size) continue;
        if (segs[w][i].len == rq.size) begin
          segs[w][i].is_free = 1'b0;
          segs[w][i].owner = rq.owner;
          r.status = ffsa_pkg::ST_OK;
          r.grant = segs[w][i].base;
          return r;
        end
        if (seg_cnt[w] >= NSEG) begin
          r.status = ffsa_pkg::ST_FULL;
          return r;
        end
        for (int k = seg_cnt[w]; k > i; k--) segs[w][k] = segs[w][k-1];
        seg_cnt[w]++;
        segs[w][i].is_free = 1'b0;
        segs[w][i].owner = rq.owner;
        segs[w][i].len = rq.size;
        segs[w][i+1].base = segs[w][i+1].base + rq.size[ffsa_pkg::START_W-1:0];
        segs[w][i+1].len = segs[w][i+1].len - rq.size;
        r.status = ffsa_pkg::ST_OK;
        r.grant = segs[w][i].base;
        return r;
      end
      return r;
    end
    r.status = ffsa_pkg::ST_NOT_FOUND;
    for (i = 0; i < seg_cnt[w]; i++) begin
      if (segs[w][i].is_free || segs[w][i].owner != rq.owner ||
          segs[w][i].base != rq.bstart) continue;
      segs[w][i].is_free = 1'b1;
      segs[w][i].owner = '0;
      if (i > 0 && segs[w][i-1].is_free) begin
        segs[w][i-1].len = segs[w][i-1].len + segs[w][i].len;
        remove_entry(w, i);
        i--;
      end
      if (i + 1 < seg_cnt[w] && segs[w][i+1].is_free) begin
        segs[w][i].len = segs[w][i].len + segs[w][i+1].len;
        remove_entry(w, i + 1);
      end
      r.status = ffsa_pkg::ST_OK;
      return r;
    end
    return r;
  endfunction

  task automatic queue_word(input logic cmd, input int own, input int sz, input int bs);
    request_t rq;
    reply_t unused;
    rq.cmd = cmd;
    rq.owner = own[ffsa_pkg::OWNER_W-1:0];
    rq.size = sz[ffsa_pkg::SIZE_W-1:0];
    rq.bstart = bs[ffsa_pkg::START_W-1:0];
    unused = allocate_or_release(TAB_PLAN, rq);
    pending_words.insert(pending_words.size(), rq);
  endtask

  // Frees a live block, with the right owner most of the time, or sends a random free if none is live.
  task automatic queue_release_live();
    int idx[$];
    int k;
    for (int i = 0; i < seg_cnt[TAB_PLAN]; i++)
      if (!segs[TAB_PLAN][i].is_free) idx.insert(idx.size(), i);
    if (idx.size() == 0) begin
      queue_word(ffsa_pkg::CMD_FREE, $urandom, 0, $urandom);
      return;
    end
    k = idx[$urandom_range(0, idx.size() - 1)];
    if ($urandom_range(0, 9) == 0)
      queue_word(ffsa_pkg::CMD_FREE, segs[TAB_PLAN][k].owner ^ 8'h01, $urandom,
                 segs[TAB_PLAN][k].base);
    else
      queue_word(ffsa_pkg::CMD_FREE, segs[TAB_PLAN][k].owner, $urandom,
                 segs[TAB_PLAN][k].base);
  endtask

  task automatic queue_random_word();
    int sel, k, cap;
    sel = $urandom_range(0, 99);
    cap = (heap_units / 6 > 1) ? heap_units / 6 : 1;
    if (sel < 40) begin
      queue_word(ffsa_pkg::CMD_ALLOC, $urandom, $urandom_range(1, cap), $urandom);
    end else if (sel < 50) begin
      // Ask for the full length of a random segment, which fits exactly if it is free.
      k = $urandom_range(0, seg_cnt[TAB_PLAN] - 1);
      queue_word(ffsa_pkg::CMD_ALLOC, $urandom, segs[TAB_PLAN][k].len, $urandom);
    end else if (sel < 85) begin
      queue_release_live();
    end else if (sel < 92) begin
      queue_word(ffsa_pkg::CMD_FREE, $urandom, $urandom, $urandom);
    end else begin
      queue_word(ffsa_pkg::CMD_ALLOC, $urandom, $urandom_range(0, 131071), $urandom);
    end
  endtask

  task automatic write_heap_size(input int value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ffsa_pkg::REG_HEAP_SIZE;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    value = value & 32'h1FFFF;
    if (value == 0) value = 1;
    if (value > HEAP_MAX) value = HEAP_MAX;
    heap_units = value;
    table_reload(TAB_CHECK);
    table_reload(TAB_PLAN);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || start || expected_replies.size() != 0);
    repeat (2 * NSEG + 10) @(posedge clk);
  endtask

  // Driver: a word is taken at an edge where start is high and busy low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_replies.insert(expected_replies.size(),
                                allocate_or_release(TAB_CHECK, word_on_bus));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() != 0) begin
          word_on_bus = pending_words.pop_front();
          start <= 1'b1;
          command <= word_on_bus.cmd;
          owner_id <= word_on_bus.owner;
          request_size <= word_on_bus.size;
          block_start <= word_on_bus.bstart;
          if (quiet_phase || $urandom_range(0, 9) < 6) gap_left = 0;
          else if ($urandom_range(0, 9) < 8) gap_left = $urandom_range(1, 3);
          else gap_left = $urandom_range(8, 40);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every reply is held for one cycle only.
  always @(posedge clk) begin
    reply_t want;
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        report("unexpected reply status", status, 0);
      end else begin
        want = expected_replies.pop_front();
        if (status !== want.status) report("status", status, want.status);
        if (granted_start !== want.grant) report("granted_start", granted_start, want.grant);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int sizes[8];
    heap_units = HEAP_MAX;
    table_reload(TAB_CHECK);
    table_reload(TAB_PLAN);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed words on the reset table.
    quiet_phase = 1;
    queue_word(ffsa_pkg::CMD_ALLOC, 8'h11, 0, 0);
    queue_word(ffsa_pkg::CMD_ALLOC, 8'h11, 131071, 16'hFFFF);
    queue_word(ffsa_pkg::CMD_ALLOC, 8'hFF, 65536, 0);
    queue_word(ffsa_pkg::CMD_FREE, 8'h00, 0, 0);
    queue_word(ffsa_pkg::CMD_FREE, 8'hFF, 1, 0);
    queue_word(ffsa_pkg::CMD_FREE, 8'hFF, 1, 0);
    for (int i = 0; i < 16; i++) queue_word(ffsa_pkg::CMD_ALLOC, i, 1, 0);
    queue_word(ffsa_pkg::CMD_FREE, 2, 0, 2);
    queue_word(ffsa_pkg::CMD_FREE, 4, 0, 4);
    queue_word(ffsa_pkg::CMD_FREE, 3, 0, 3);
    queue_word(ffsa_pkg::CMD_FREE, 0, 0, 0);
    queue_word(ffsa_pkg::CMD_ALLOC, 8'h80, 3, 0);
    drain();

    // Random phases over several heap sizes, the extremes among them.
    sizes = '{131071, 0, 1, 2, 65536, 40, 1000, 12345};
    for (int p = 0; p < 8; p++) begin
      write_heap_size(sizes[p]);
      quiet_phase = (p == 3 || p == 6);
      for (int n = 0; n < 118; n++) queue_random_word();
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
